// ===== hw/rtl/sorted_keyed_table_merge_top_assert.svh =====
// assertion macros for the sorted table block
`ifndef SORTED_KEYED_TABLE_MERGE_TOP_ASSERT_SVH
`define SORTED_KEYED_TABLE_MERGE_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SKTM_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SKTM_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// ===== hw/rtl/sktm_pkg.sv =====
package sktm_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int NAME_CHARS_DEF  = 25;
    localparam int NAME_BITS       = 208;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_BEYOND   = 3'd5
    } status_t;

    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // one table entry
    typedef struct packed {
        logic [31:0]          key;
        logic [NAME_BITS-1:0] name;
        logic [31:0]          qty;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic        insert;
        logic        merge;
        logic [31:0] sum;
        entry_t      ent;
    } cell_cmd_t;

    // name mask for a name of n bytes
    function automatic logic [NAME_BITS-1:0] name_mask(input int n);
        logic [NAME_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < NAME_BITS / 8; b++)
        begin
            if (b < n)
                m[b*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

    // signed 32-bit saturating add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        return s[31:0];
    endfunction

endpackage

// ===== hw/rtl/sktm_if.sv =====
interface sktm_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] part_number;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [15:0] name_word3;
    logic [31:0] quantity;
    logic [6:0]  read_index;
    modport source (output valid, op, part_number, name_word0, name_word1, name_word2,
                    name_word3, quantity, read_index, input ready);
    modport sink (input valid, op, part_number, name_word0, name_word1, name_word2,
                  name_word3, quantity, read_index, output ready);
endinterface

interface sktm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  entry_count;
    logic [31:0] out_part_number;
    logic [63:0] out_name_word0;
    logic [63:0] out_name_word1;
    logic [63:0] out_name_word2;
    logic [15:0] out_name_word3;
    logic [31:0] out_quantity;
    modport source (output valid, status, entry_count, out_part_number, out_name_word0,
                    out_name_word1, out_name_word2, out_name_word3, out_quantity,
                    input ready);
    modport sink (input valid, status, entry_count, out_part_number, out_name_word0,
                  out_name_word1, out_name_word2, out_name_word3, out_quantity,
                  output ready);
endinterface

// ===== hw/rtl/sktm_cell.sv =====
module sktm_cell
(
    input  logic               clk,
    input  sktm_pkg::cell_cmd_t cmd,
    input  logic               sel,
    input  logic               at_pos,
    input  logic               shift,
    input  sktm_pkg::entry_t   left,
    output sktm_pkg::entry_t   ent
);

    sktm_pkg::entry_t ent_reg;
    sktm_pkg::entry_t ent_next;

    // shift from neighbor, load new entry, or update quantity
    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.insert && shift)
            ent_next = left;
        else if (cmd.insert && at_pos)
            ent_next = cmd.ent;
        else if (cmd.merge && sel)
            ent_next.qty = cmd.sum;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// ===== hw/rtl/sorted_keyed_table_merge_top.sv =====
// channel | dir | payload
// in      | in  | op, part_number, name_word0..3, quantity, read_index
// out     | out | status, entry_count, out_part_number, out_name_word0..3, out_quantity
// an item is latched in its accept cycle, then the update state compares all cells
// of the chain and shifts, loads or merges them in parallel
// the result register frees as soon as taken; the next item enters while it waits
// reset clears the count and control only; entries are defined once written
// a stalled result holds the update of the following item, and so the input, until taken
module sorted_keyed_table_merge_top #(
    parameter int TABLE_DEPTH = sktm_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_CHARS  = sktm_pkg::NAME_CHARS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    sktm_in_if.sink    in_ch,
    sktm_out_if.source out_ch
);

    `include "sorted_keyed_table_merge_top_assert.svh"

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [sktm_pkg::NAME_BITS-1:0] MASK = sktm_pkg::name_mask(NAME_CHARS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic op_reg;
    logic [6:0] idx_reg;
    sktm_pkg::entry_t item_reg;
    logic out_valid_reg;
    sktm_pkg::status_t status_reg;
    logic [7:0] ocount_reg;
    sktm_pkg::entry_t oent_reg;

    sktm_pkg::entry_t cells [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit, less, shift, at_pos;
    logic any_hit, name_eq;
    sktm_pkg::entry_t hit_ent, rd_ent;
    sktm_pkg::cell_cmd_t cmd;
    sktm_pkg::status_t st;
    logic full;
    logic take;
    logic upd_go;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign take = in_ch.valid && in_ch.ready;

    // update proceeds once the result register is free or being taken
    assign upd_go = (state_reg == S_UPD) && (!out_valid_reg || out_ch.ready);

    // latch item
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg        <= in_ch.op;
            idx_reg       <= in_ch.read_index;
            item_reg.key  <= in_ch.part_number;
            item_reg.name <= {in_ch.name_word3, in_ch.name_word2, in_ch.name_word1,
                              in_ch.name_word0} & MASK;
            item_reg.qty  <= in_ch.quantity;
        end
    end

    // per-cell compare against the latched key
    always_comb
    begin
        hit_ent = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit[i]  = (i < count_reg) && (cells[i].key == item_reg.key);
            less[i] = (i < count_reg) && ($signed(cells[i].key) < $signed(item_reg.key));
            at_pos[i] = (i < count_reg) ? !less[i] && (i == 0 || less[i-1])
                                        : (i == count_reg) && (i == 0 || less[i-1]);
            shift[i]  = (i != 0) && (i <= count_reg) && !less[i-1];
            if (hit[i])
                hit_ent = cells[i];
        end
        any_hit = |hit;
        name_eq = (hit_ent.name == item_reg.name);
    end

    assign full = (count_reg >= CW'(TABLE_DEPTH));
    assign rd_ent = cells[idx_reg[IW-1:0]];

    always_comb
    begin
        if (op_reg == sktm_pkg::OP_READ)
            st = ({1'b0, idx_reg} < 8'(count_reg) && 32'(idx_reg) < TABLE_DEPTH)
                 ? sktm_pkg::ST_READ_OK : sktm_pkg::ST_BEYOND;
        else if (any_hit)
            st = name_eq ? sktm_pkg::ST_MERGED : sktm_pkg::ST_MISMATCH;
        else if (full)
            st = sktm_pkg::ST_FULL;
        else
            st = sktm_pkg::ST_INSERTED;
        cmd.insert = upd_go && (st == sktm_pkg::ST_INSERTED);
        cmd.merge  = upd_go && (st == sktm_pkg::ST_MERGED);
        cmd.sum    = sktm_pkg::sat_add(hit_ent.qty, item_reg.qty);
        cmd.ent    = item_reg;
    end

    // the chain of cells
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        sktm_cell u_cell (
            .clk    (clk),
            .cmd    (cmd),
            .sel    (hit[g]),
            .at_pos (at_pos[g]),
            .shift  (shift[g]),
            .left   (cells[(g == 0) ? 0 : g-1]),
            .ent    (cells[g])
        );
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE: if (take) state_next = S_UPD;
            S_UPD:
            begin
                if (upd_go)
                    state_next = S_IDLE;
                if (cmd.insert)
                    count_next = count_reg + 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (upd_go)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            status_reg <= st;
            ocount_reg <= 8'(count_next);
            oent_reg   <= (st == sktm_pkg::ST_READ_OK) ? rd_ent : '0;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = status_reg;
    assign out_ch.entry_count     = ocount_reg;
    assign out_ch.out_part_number = oent_reg.key;
    assign out_ch.out_name_word0  = oent_reg.name[63:0];
    assign out_ch.out_name_word1  = oent_reg.name[127:64];
    assign out_ch.out_name_word2  = oent_reg.name[191:128];
    assign out_ch.out_name_word3  = oent_reg.name[207:192];
    assign out_ch.out_quantity    = oent_reg.qty;

    `SKTM_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(TABLE_DEPTH),
        "count above depth")
    `SKTM_ASSERT_IMP(a_hit_one, clk, rst_n, state_reg == S_UPD, $onehot0(hit),
        "duplicate key in table")
    `SKTM_ASSERT_NEXT(a_insert_count, clk, rst_n, cmd.insert,
        count_reg == $past(count_reg) + 1'b1, "insert did not grow count")
    `SKTM_ASSERT_IMP(a_no_take_busy, clk, rst_n, state_reg == S_UPD, !in_ch.ready,
        "input taken during update")

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 128;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic        op;
        logic [31:0] key;
        logic [63:0] w0, w1, w2;
        logic [15:0] w3;
        logic [31:0] qty;
        logic [6:0]  idx;
    } record_t;

    typedef struct {
        sktm_pkg::status_t st;
        logic [7:0]  cnt;
        logic [31:0] key;
        logic [63:0] w0, w1, w2;
        logic [15:0] w3;
        logic [31:0] qty;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sktm_in_if  in_ch ();
    sktm_out_if out_ch ();

    sorted_keyed_table_merge_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    // shadow of the table
    logic [31:0]  tbl_key [DEPTH];
    logic [207:0] tbl_name [DEPTH];
    logic [31:0]  tbl_qty [DEPTH];
    int           tbl_cnt = 0;

    record_t pending_records[$];
    reply_t  expected_replies[$];
    int      mismatches = 0;
    int      merges_seen = 0;
    int      reads_seen = 0;
    int      idle_cycles = 0;
    bit      calm = 1'b0;
    bit      stim_done = 1'b0;
    int      drv_gap = 0;
    int      mon_gap = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // compute the reply for one record and update the shadow table
    function automatic reply_t apply_record(record_t r);
        reply_t       y;
        logic [207:0] nm;
        int           i, p;
        logic [32:0]  s;
        y = '{sktm_pkg::ST_INSERTED, 8'd0, 32'd0, 64'd0, 64'd0, 64'd0, 16'd0, 32'd0};
        if (r.op == sktm_pkg::OP_READ)
        begin
            if (r.idx < tbl_cnt)
            begin
                y.st = sktm_pkg::ST_READ_OK;
                y.key = tbl_key[r.idx];
                {y.w3, y.w2, y.w1, y.w0} = tbl_name[r.idx];
                y.qty = tbl_qty[r.idx];
            end
            else
                y.st = sktm_pkg::ST_BEYOND;
            y.cnt = tbl_cnt[7:0];
            return y;
        end
        nm = {r.w3, r.w2, r.w1, r.w0};
        nm[207:200] = 8'd0;
        for (i = 0; i < tbl_cnt; i++)
            if (tbl_key[i] == r.key)
                break;
        if (i < tbl_cnt)
        begin
            if (tbl_name[i] != nm)
                y.st = sktm_pkg::ST_MISMATCH;
            else
            begin
                s = {tbl_qty[i][31], tbl_qty[i]} + {r.qty[31], r.qty};
                if (s[32] != s[31])
                    tbl_qty[i] = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                else
                    tbl_qty[i] = s[31:0];
                y.st = sktm_pkg::ST_MERGED;
            end
        end
        else if (tbl_cnt >= DEPTH)
            y.st = sktm_pkg::ST_FULL;
        else
        begin
            p = 0;
            while (p < tbl_cnt && $signed(tbl_key[p]) < $signed(r.key))
                p++;
            for (i = tbl_cnt; i > p; i--)
            begin
                tbl_key[i] = tbl_key[i-1];
                tbl_name[i] = tbl_name[i-1];
                tbl_qty[i] = tbl_qty[i-1];
            end
            tbl_key[p] = r.key;
            tbl_name[p] = nm;
            tbl_qty[p] = r.qty;
            tbl_cnt++;
            y.st = sktm_pkg::ST_INSERTED;
        end
        y.cnt = tbl_cnt[7:0];
        return y;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // keys drawn from a small pool so hits are common
    function automatic logic [31:0] pool_key(int pool);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 32'h8000_0000;
        if (k == 1)
            return 32'h7fff_ffff;
        return $urandom_range(0, pool) - pool / 2;
    endfunction

    function automatic record_t make_merge(logic [31:0] k, logic [31:0] q);
        record_t r;
        int      sel;
        r.op = sktm_pkg::OP_MERGE;
        r.key = k;
        sel = k[2:0];
        // names tied to the key, with occasional noise
        r.w0 = {k, ~k} ^ 64'(sel);
        r.w1 = {~k, k};
        r.w2 = 64'h0102_0304_0506_0708 ^ 64'(k);
        r.w3 = k[15:0];
        if ($urandom_range(0, 9) == 0)
        begin
            r.w0 = rand64();
            r.w3 = 16'($urandom);
        end
        r.qty = q;
        r.idx = 7'($urandom);
        return r;
    endfunction

    function automatic record_t make_read(logic [6:0] i);
        record_t r;
        r.op = sktm_pkg::OP_READ;
        r.key = $urandom;
        r.w0 = rand64();
        r.w1 = rand64();
        r.w2 = rand64();
        r.w3 = 16'($urandom);
        r.qty = $urandom;
        r.idx = i;
        return r;
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 4))
            0: return 32'h7fff_fff0 + $urandom_range(0, 15);
            1: return 32'h8000_0000 + $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial
    begin
        record_t r;
        int      n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // directed part
        pending_records.push_back(make_read(7'd0));
        pending_records.push_back(make_merge(32'h8000_0000, 32'h7fff_ffff));
        pending_records.push_back(make_merge(32'h7fff_ffff, 32'h8000_0000));
        pending_records.push_back(make_merge(32'd0, 32'd5));
        r = make_merge(32'h8000_0000, 32'd1);
        r.w0 = {32'h0, 32'h8000_0000} ^ 64'hFFFF_FFFF_8000_0000 ^ 64'hFFFF_FFFF_8000_0000;
        pending_records.push_back(make_merge(32'h8000_0000, 32'd1));
        pending_records.push_back(make_merge(32'h7fff_ffff, 32'h8000_0000));
        r = make_merge(32'd0, 32'd1);
        r.w3 = ~r.w3;
        pending_records.push_back(r);
        // high byte of the last word is beyond the name and must be ignored
        r = make_merge(32'd0, 32'd2);
        r.w3[15:8] = 8'hff;
        pending_records.push_back(r);
        r = make_merge(32'd9, 32'hffff_ffff);
        r.w0 = '1;
        r.w1 = '1;
        r.w2 = '1;
        r.w3 = '1;
        pending_records.push_back(r);
        for (int i = 0; i < 5; i++)
            pending_records.push_back(make_read(7'(i)));
        pending_records.push_back(make_read(7'd127));
        // random part, fill to full then keep merging
        n = 0;
        while (n < 960)
        begin
            if ($urandom_range(0, 3) == 0)
                pending_records.push_back(make_read($urandom_range(0, 3) == 0 ?
                    7'($urandom) : 7'($urandom_range(0, 127))));
            else if (n < 500)
                pending_records.push_back(make_merge(pool_key(300), rand_qty()));
            else
                pending_records.push_back(make_merge($urandom_range(0, 1) ?
                    32'($urandom) : pool_key(300), rand_qty()));
            n++;
        end
        for (int i = 0; i < 128; i++)
            pending_records.push_back(make_read(7'(i)));
        stim_done = 1'b1;
        // no idling over the last part of the run
        wait (pending_records.size() < 200);
        calm = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        record_t r;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.op <= sktm_pkg::OP_MERGE;
            in_ch.part_number <= '0;
            in_ch.name_word0 <= '0;
            in_ch.name_word1 <= '0;
            in_ch.name_word2 <= '0;
            in_ch.name_word3 <= '0;
            in_ch.quantity <= '0;
            in_ch.read_index <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                r.op = in_ch.op;
                r.key = in_ch.part_number;
                r.w0 = in_ch.name_word0;
                r.w1 = in_ch.name_word1;
                r.w2 = in_ch.name_word2;
                r.w3 = in_ch.name_word3;
                r.qty = in_ch.quantity;
                r.idx = in_ch.read_index;
                expected_replies.push_back(apply_record(r));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap <= drv_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    drv_gap <= $urandom_range(0, 14);
                    in_ch.valid <= 1'b0;
                end
                else if (pending_records.size() > 0)
                begin
                    r = pending_records.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.op <= r.op;
                    in_ch.part_number <= r.key;
                    in_ch.name_word0 <= r.w0;
                    in_ch.name_word1 <= r.w1;
                    in_ch.name_word2 <= r.w2;
                    in_ch.name_word3 <= r.w3;
                    in_ch.quantity <= r.qty;
                    in_ch.read_index <= r.idx;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        reply_t y;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction status=%0d", out_ch.status);
                end
                else
                begin
                    y = expected_replies.pop_front();
                    if (y.st == sktm_pkg::ST_MERGED)
                        merges_seen++;
                    if (y.st == sktm_pkg::ST_READ_OK)
                        reads_seen++;
                    if (out_ch.status !== y.st || out_ch.entry_count !== y.cnt ||
                        out_ch.out_part_number !== y.key ||
                        out_ch.out_name_word0 !== y.w0 || out_ch.out_name_word1 !== y.w1 ||
                        out_ch.out_name_word2 !== y.w2 || out_ch.out_name_word3 !== y.w3 ||
                        out_ch.out_quantity !== y.qty)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch exp st=%0d cnt=%0d key=%h name=%h_%h_%h_%h q=%h",
                                y.st, y.cnt, y.key, y.w3, y.w2, y.w1, y.w0, y.qty);
                            $display("         got st=%0d cnt=%0d key=%h name=%h_%h_%h_%h q=%h",
                                out_ch.status, out_ch.entry_count, out_ch.out_part_number,
                                out_ch.out_name_word3, out_ch.out_name_word2,
                                out_ch.out_name_word1, out_ch.out_name_word0,
                                out_ch.out_quantity);
                        end
                    end
                end
            end
            if (mon_gap > 0)
            begin
                mon_gap <= mon_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                mon_gap <= $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        wait (pending_records.size() == 0 && !in_ch.valid);
        wait (expected_replies.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d merges into existing keys, %0d valid reads, final table size %0d",
            merges_seen, reads_seen, tbl_cnt);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sktm_pkg.sv
hw/rtl/sktm_if.sv
hw/rtl/sktm_cell.sv
hw/rtl/sorted_keyed_table_merge_top.sv
tb/tb.sv
